### rtl/core/ptb_pkg.sv
// Shared types and constants for the Sv39 page table builder.
package ptb_pkg;

    localparam int TABLE_PAGES       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int VPN_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_W            = $clog2(TABLE_PAGES);
    localparam int NFP_W             = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W            = PAGE_W + VPN_W;
    localparam int DEPTH             = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int PAGE_SHIFT        = 12;
    localparam int PPN_W             = 44;
    localparam int VA_W              = 39;
    localparam int PA_W              = 56;
    localparam int SIZE_W            = 32;
    localparam int PERM_W            = 3;
    localparam int CNT_W             = 21;
    localparam int POOL_W            = 9;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 44;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 1'd1;

    typedef struct packed {
        logic [VA_W-1:0]   virt_addr;
        logic [PA_W-1:0]   phys_addr;
        logic [SIZE_W-1:0] size_bytes;
        logic [PERM_W-1:0] perm;
    } req_t;

    typedef struct packed {
        logic             status;
        logic [CNT_W-1:0] pages_mapped;
    } rsp_t;

    // Stored PTE: only the fields the builder produces (PPN, XWR, V).
    typedef struct packed {
        logic [PPN_W-1:0]  ppn;
        logic [PERM_W-1:0] xwr;
        logic              v;
    } pte_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        pte_t              data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

endpackage

### rtl/core/ptb_table_ram.sv
// Table store: one write port, one read port, registered read data.
module ptb_table_ram (
    input  logic            clk,
    input  ptb_pkg::ram_wr_t wr,
    input  ptb_pkg::ram_rd_t rd,
    output ptb_pkg::pte_t   rdata
);
    import ptb_pkg::*;

    pte_t mem [DEPTH];
    pte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/page_table_builder.sv
// Top level of the Sv39 page table builder.
// Builds three-level Sv39 tables in an internal pool of TABLE_PAGES table pages
// held in one RAM with one write port, one read port and registered read data.
// After reset the block clears the root page, one entry a cycle, and stalls
// requests until done. A request maps ceil(size_bytes/4096) pages; each page
// takes two read/check pairs plus the leaf write when its level-2 and level-1
// tables exist, and each table allocated on the way adds clearing the fresh
// page and linking it. After the last page the result beat passes S_POST,
// which waits for the output slot, into the output register; a zero size goes
// straight from idle to S_POST. A new request is taken while the previous
// result still waits at the output. When a needed table cannot be allocated,
// or a valid pointer names a pool page not yet allocated, the request stops
// with status 1 and reports the pages mapped so far.
module page_table_builder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  ptb_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ptb_pkg::rsp_t                       rsp,
    input  logic                                cfg_we,
    input  logic [ptb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ptb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ptb_pkg::*;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_ZERO  = 8'b0001_0000,
        S_LINK  = 8'b0010_0000,
        S_LEAF  = 8'b0100_0000,
        S_POST  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [PPN_W-1:0]   base_reg;
    logic [POOL_W-1:0]  pool_reg;
    logic [NFP_W-1:0]   nfp_reg, nfp_next;
    logic [VA_W-1:0]    va_reg, va_next;
    logic [PA_W-1:0]    pa_reg, pa_next;
    logic [PERM_W-1:0]  perm_reg, perm_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    logic               top_reg, top_next;      // high while walking level 2
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [PAGE_W-1:0]  fresh_reg, fresh_next;
    logic [ADDR_W-1:0]  link_reg, link_next;    // entry that gets the pointer PTE
    logic [VPN_W-1:0]   clr_reg, clr_next;
    logic               status_reg, status_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    ram_wr_t            wr;
    ram_rd_t            rd;
    pte_t               rdata;

    logic [POOL_W-1:0]  limit;
    logic [PPN_W-1:0]   rel;
    logic [VPN_W-1:0]   vpn_walk;
    logic [CNT_W-1:0]   done_inc;

    ptb_table_ram u_ram (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    always_comb
    begin
        if (pool_reg == '0)
        begin
            limit = POOL_W'(1);
        end
        else if (pool_reg > POOL_W'(TABLE_PAGES))
        begin
            limit = POOL_W'(TABLE_PAGES);
        end
        else
        begin
            limit = pool_reg;
        end
    end

    assign rel      = rdata.ppn - base_reg;
    assign vpn_walk = top_reg ? va_reg[VA_W-1 -: VPN_W]
                              : va_reg[PAGE_SHIFT + 2*VPN_W - 1 -: VPN_W];
    assign done_inc = done_reg + CNT_W'(1);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        nfp_next       = nfp_reg;
        va_next        = va_reg;
        pa_next        = pa_reg;
        perm_next      = perm_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        top_next       = top_reg;
        page_next      = page_reg;
        fresh_next     = fresh_reg;
        link_next      = link_reg;
        clr_next       = clr_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr             = '0;
        rd             = '0;

        case (state_reg)
            S_INIT:
            begin
                wr.en    = 1'b1;
                wr.addr  = {PAGE_W'(0), clr_reg};
                wr.data  = '0;
                clr_next = clr_reg + VPN_W'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    va_next     = req.virt_addr;
                    pa_next     = req.phys_addr;
                    perm_next   = req.perm;
                    count_next  = CNT_W'(req.size_bytes[SIZE_W-1:PAGE_SHIFT])
                                + CNT_W'(|req.size_bytes[PAGE_SHIFT-1:0]);
                    done_next   = '0;
                    status_next = 1'b0;
                    top_next    = 1'b1;
                    page_next   = '0;
                    state_next  = (req.size_bytes == '0) ? S_POST : S_READ;
                end
            end
            S_READ:
            begin
                rd.en      = 1'b1;
                rd.addr    = {page_reg, vpn_walk};
                link_next  = {page_reg, vpn_walk};
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rdata.v)
                begin
                    if (rel >= PPN_W'(nfp_reg))
                    begin
                        status_next = 1'b1;
                        state_next  = S_POST;
                    end
                    else
                    begin
                        page_next = rel[PAGE_W-1:0];
                        if (top_reg)
                        begin
                            top_next   = 1'b0;
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_LEAF;
                        end
                    end
                end
                else if (POOL_W'(nfp_reg) >= limit)
                begin
                    status_next = 1'b1;
                    state_next  = S_POST;
                end
                else
                begin
                    fresh_next = nfp_reg[PAGE_W-1:0];
                    nfp_next   = nfp_reg + NFP_W'(1);
                    clr_next   = '0;
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                wr.en    = 1'b1;
                wr.addr  = {fresh_reg, clr_reg};
                wr.data  = '0;
                clr_next = clr_reg + VPN_W'(1);
                if (&clr_reg)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                wr.en       = 1'b1;
                wr.addr     = link_reg;
                wr.data.ppn = base_reg + PPN_W'(fresh_reg);
                wr.data.xwr = '0;
                wr.data.v   = 1'b1;
                page_next   = fresh_reg;
                if (top_reg)
                begin
                    top_next   = 1'b0;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                wr.en       = 1'b1;
                wr.addr     = {page_reg, va_reg[PAGE_SHIFT + VPN_W - 1 -: VPN_W]};
                wr.data.ppn = pa_reg[PA_W-1:PAGE_SHIFT];
                wr.data.xwr = perm_reg;
                wr.data.v   = 1'b1;
                done_next   = done_inc;
                va_next     = {va_reg[VA_W-1:PAGE_SHIFT] + (VA_W-PAGE_SHIFT)'(1),
                               va_reg[PAGE_SHIFT-1:0]};
                pa_next     = {pa_reg[PA_W-1:PAGE_SHIFT] + (PA_W-PAGE_SHIFT)'(1),
                               pa_reg[PAGE_SHIFT-1:0]};
                top_next    = 1'b1;
                page_next   = '0;
                state_next  = (done_inc == count_reg) ? S_POST : S_READ;
            end
            S_POST:
            begin
                // wait for the output slot, then hand over the result beat
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status       = status_reg;
                    rsp_next.pages_mapped = done_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            base_reg      <= '0;
            pool_reg      <= POOL_W'(16);
            nfp_reg       <= NFP_W'(1);
            top_reg       <= 1'b1;
            page_reg      <= '0;
            fresh_reg     <= '0;
            clr_reg       <= '0;
            count_reg     <= '0;
            done_reg      <= '0;
            status_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nfp_reg       <= nfp_next;
            top_reg       <= top_next;
            page_reg      <= page_next;
            fresh_reg     <= fresh_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POOL_BASE:  base_reg <= cfg_data[PPN_W-1:0];
                    CFG_POOL_PAGES: pool_reg <= cfg_data[POOL_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg   <= va_next;
        pa_reg   <= pa_next;
        perm_reg <= perm_next;
        link_reg <= link_next;
        rsp_reg  <= rsp_next;
    end

endmodule
